>>> design/gcdc_pkg.sv
// Shared types and constants for the grid dilation counter.
package gcdc_pkg;

    localparam int MAX_SIDE_DEF = 64;

    localparam int SIDE_CFG_W = 7;
    localparam int DAYS_W     = 10;
    localparam int OUT_W      = 13;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAYS = 1'b1;

    localparam logic [SIDE_CFG_W-1:0] SIDE_RST = 7'd64;
    localparam logic [DAYS_W-1:0]     DAYS_RST = 10'd1;

    typedef enum logic [KIND_W-1:0] {
        K_HEALTHY  = 2'd0,
        K_INFECTED = 2'd1,
        K_BLOCKED  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PR_SELF,
        PR_UP,
        PR_DOWN,
        PR_LEFT,
        PR_RIGHT
    } probe_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_PROBE,
        S_EVAL,
        S_COUNT,
        S_CNT_LAST,
        S_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic wr_bank;
        logic rd_bank;
    } mem_ctl_t;

    function automatic probe_t next_probe(input probe_t p);
        probe_t n;
        unique case (p)
            PR_SELF:  n = PR_UP;
            PR_UP:    n = PR_DOWN;
            PR_DOWN:  n = PR_LEFT;
            PR_LEFT:  n = PR_RIGHT;
            default:  n = PR_SELF;
        endcase
        return n;
    endfunction

endpackage

>>> design/grid_constrained_dilation_count.sv
// Loading writes one cell per accepted input beat; a grid of n*n cells then runs its spread rounds.
// Each round visits every cell through one shared probe unit and the single bank read port:
// a non-healthy cell keeps its kind, a healthy one probes up, down, left, right in turn;
// rounds stop early once none change. Counting then reads every cell into the result register.
// Input is ready only while loading; a waiting result does not block the next load.
// Reset (synchronous, active low): side 64, days 1, load position 0; grid banks are not cleared.
module grid_constrained_dilation_count #(
    parameter int MAX_SIDE = gcdc_pkg::MAX_SIDE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [1:0] cell_kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [12:0] infected_total
    input  logic                             cfg_wr_en,
    input  logic [gcdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gcdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import gcdc_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int CELL_AW = $clog2(MAX_SIDE * MAX_SIDE);

    logic [SIDE_CFG_W-1:0] side_reg;
    logic [DAYS_W-1:0]     days_reg;
    logic [7:0]            side_ext;
    logic [7:0]            side_clip;
    logic [SIDE_W-1:0]     eff_side;
    logic [DAYS_W-1:0]     rounds;

    mem_ctl_t              ctl;
    logic [CELL_AW-1:0]    wr_addr;
    kind_t                 wr_data;
    logic [CELL_AW-1:0]    rd_addr;
    kind_t                 rd_data0;
    kind_t                 rd_data1;
    kind_t                 rd_data;
    logic [OUT_W-1:0]      m_total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_RST;
            days_reg <= DAYS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SIDE: side_reg <= cfg_wdata[SIDE_CFG_W-1:0];
                CFG_DAYS: days_reg <= cfg_wdata[DAYS_W-1:0];
            endcase
        end
    end

    // side 0 acts as 1, anything above the grid size as the grid size
    assign side_ext  = {1'b0, side_reg};
    assign side_clip = (side_ext == 8'd0)           ? 8'd1 :
                       (side_ext > 8'(MAX_SIDE))    ? 8'(MAX_SIDE) : side_ext;
    assign eff_side  = SIDE_W'(side_clip);
    assign rounds    = (days_reg == '0) ? '0 : days_reg - DAYS_W'(1);

    gcdc_seq #(
        .MAX_SIDE (MAX_SIDE),
        .SIDE_W   (SIDE_W),
        .CELL_AW  (CELL_AW)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .eff_side (eff_side),
        .rounds   (rounds),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind_in  (s_tdata[KIND_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_total  (m_total),
        .ctl      (ctl),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    gcdc_bank #(.ADDR_W(CELL_AW)) u_bank0 (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en && !ctl.wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    gcdc_bank #(.ADDR_W(CELL_AW)) u_bank1 (
        .aclk    (aclk),
        .wr_en   (ctl.wr_en && ctl.wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    assign rd_data = ctl.rd_bank ? rd_data1 : rd_data0;
    assign m_tdata = {{(16 - OUT_W){1'b0}}, m_total};

endmodule

>>> design/gcdc_bank.sv
// One grid bank: single write port, single registered read port.
module gcdc_bank #(
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  gcdc_pkg::kind_t   wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output gcdc_pkg::kind_t   rd_data
);
    import gcdc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    kind_t mem [DEPTH];
    kind_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/gcdc_seq.sv
// Sequencer: cell load, neighbor probing per round, infected count, result register.
module gcdc_seq #(
    parameter int MAX_SIDE = gcdc_pkg::MAX_SIDE_DEF,
    parameter int SIDE_W   = $clog2(MAX_SIDE + 1),
    parameter int CELL_AW  = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [SIDE_W-1:0]            eff_side,
    input  logic [gcdc_pkg::DAYS_W-1:0]  rounds,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [gcdc_pkg::KIND_W-1:0]  kind_in,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gcdc_pkg::OUT_W-1:0]   m_total,
    output gcdc_pkg::mem_ctl_t           ctl,
    output logic [CELL_AW-1:0]           wr_addr,
    output gcdc_pkg::kind_t              wr_data,
    output logic [CELL_AW-1:0]           rd_addr,
    input  gcdc_pkg::kind_t              rd_data
);
    import gcdc_pkg::*;

    localparam int CELL_W = CELL_AW + 1;
    localparam int PROD_W = 2 * SIDE_W;

    state_t              state_reg, state_next;
    logic [CELL_W-1:0]   load_pos_reg, load_pos_next;
    logic [CELL_AW-1:0]  idx_reg, idx_next;
    logic [SIDE_W-1:0]   row_reg, row_next;
    logic [SIDE_W-1:0]   col_reg, col_next;
    probe_t              probe_reg, probe_next;
    logic                changed_reg, changed_next;
    logic [DAYS_W-1:0]   round_reg, round_next;
    logic                cur_bank_reg, cur_bank_next;
    logic [CELL_W-1:0]   cnt_reg, cnt_next;
    logic                cnt_vld_reg, cnt_vld_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    out_reg, out_next;

    logic [PROD_W-1:0]   prod;
    logic [CELL_W-1:0]   total;
    logic [SIDE_W-1:0]   side_m1;
    logic [CELL_W-1:0]   pos_start;
    logic                last_load;
    logic                last_cell;
    kind_t               kind_cell;
    logic                probe_ok;
    logic [CELL_AW-1:0]  probe_addr;
    logic [CELL_AW-1:0]  side_a;

    logic                finish;
    kind_t               finish_val;
    logic                finish_chg;
    logic                changed_now;
    logic                begin_round;
    logic                begin_count;

    assign prod      = eff_side * eff_side;
    assign total     = CELL_W'(prod);
    assign side_m1   = eff_side - SIDE_W'(1);
    assign side_a    = CELL_AW'(eff_side);
    assign pos_start = (load_pos_reg >= total) ? '0 : load_pos_reg;
    assign last_load = (pos_start + CELL_W'(1)) == total;
    assign last_cell = (CELL_W'(idx_reg) + CELL_W'(1)) == total;

    always_comb begin
        unique case (kind_in)
            2'd0:    kind_cell = K_HEALTHY;
            2'd1:    kind_cell = K_INFECTED;
            default: kind_cell = K_BLOCKED;
        endcase
    end

    // neighbor address and bounds for the current probe
    always_comb begin
        unique case (probe_reg)
            PR_SELF: begin
                probe_ok   = 1'b1;
                probe_addr = idx_reg;
            end
            PR_UP: begin
                probe_ok   = row_reg != '0;
                probe_addr = idx_reg - side_a;
            end
            PR_DOWN: begin
                probe_ok   = row_reg != side_m1;
                probe_addr = idx_reg + side_a;
            end
            PR_LEFT: begin
                probe_ok   = col_reg != '0;
                probe_addr = idx_reg - CELL_AW'(1);
            end
            PR_RIGHT: begin
                probe_ok   = col_reg != side_m1;
                probe_addr = idx_reg + CELL_AW'(1);
            end
            default: begin
                probe_ok   = 1'b0;
                probe_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            round_reg    <= '0;
            cur_bank_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            cnt_vld_reg  <= 1'b0;
            probe_reg    <= PR_SELF;
        end else begin
            load_pos_reg <= load_pos_next;
            round_reg    <= round_next;
            cur_bank_reg <= cur_bank_next;
            m_valid_reg  <= m_valid_next;
            cnt_vld_reg  <= cnt_vld_next;
            probe_reg    <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        changed_reg <= changed_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

    always_comb begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        idx_next      = idx_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        probe_next    = probe_reg;
        changed_next  = changed_reg;
        round_next    = round_reg;
        cur_bank_next = cur_bank_reg;
        cnt_next      = cnt_reg;
        cnt_vld_next  = cnt_vld_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        out_next      = out_reg;

        s_tready      = 1'b0;
        ctl.wr_en     = 1'b0;
        ctl.wr_bank   = cur_bank_reg;
        ctl.rd_bank   = cur_bank_reg;
        wr_addr       = idx_reg;
        wr_data       = K_HEALTHY;
        rd_addr       = idx_reg;

        finish        = 1'b0;
        finish_val    = K_HEALTHY;
        finish_chg    = 1'b0;
        begin_round   = 1'b0;
        begin_count   = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.wr_en = 1'b1;
                    wr_addr   = pos_start[CELL_AW-1:0];
                    wr_data   = kind_cell;
                    if (last_load) begin
                        load_pos_next = '0;
                        state_next    = S_START;
                    end else begin
                        load_pos_next = pos_start + CELL_W'(1);
                    end
                end
            end
            S_START: begin
                round_next = '0;
                if (rounds == '0) begin
                    begin_count = 1'b1;
                end else begin
                    begin_round = 1'b1;
                end
            end
            S_PROBE: begin
                rd_addr = probe_addr;
                if (probe_ok) begin
                    state_next = S_EVAL;
                end else if (probe_reg == PR_RIGHT) begin
                    finish     = 1'b1;
                    finish_val = K_HEALTHY;
                end else begin
                    probe_next = next_probe(probe_reg);
                end
            end
            S_EVAL: begin
                if (probe_reg == PR_SELF) begin
                    if (rd_data != K_HEALTHY) begin
                        finish     = 1'b1;
                        finish_val = rd_data;
                    end else begin
                        probe_next = PR_UP;
                        state_next = S_PROBE;
                    end
                end else if (rd_data == K_INFECTED) begin
                    finish     = 1'b1;
                    finish_val = K_INFECTED;
                    finish_chg = 1'b1;
                end else if (probe_reg == PR_RIGHT) begin
                    finish     = 1'b1;
                    finish_val = K_HEALTHY;
                end else begin
                    probe_next = next_probe(probe_reg);
                    state_next = S_PROBE;
                end
            end
            S_COUNT: begin
                if (cnt_vld_reg && rd_data == K_INFECTED) begin
                    cnt_next = cnt_reg + CELL_W'(1);
                end
                cnt_vld_next = 1'b1;
                if (last_cell) begin
                    state_next = S_CNT_LAST;
                end else begin
                    idx_next = idx_reg + CELL_AW'(1);
                end
            end
            S_CNT_LAST: begin
                if (rd_data == K_INFECTED) begin
                    cnt_next = cnt_reg + CELL_W'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_next     = OUT_W'(cnt_reg);
                    state_next   = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase

        changed_now = changed_reg | finish_chg;

        // new value goes to the other bank; old grid stays readable all round
        if (finish) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_bank = ~cur_bank_reg;
            wr_addr     = idx_reg;
            wr_data     = finish_val;
            probe_next  = PR_SELF;
            state_next  = S_PROBE;
            if (last_cell) begin
                cur_bank_next = ~cur_bank_reg;
                round_next    = round_reg + DAYS_W'(1);
                if (!changed_now || (round_reg + DAYS_W'(1)) == rounds) begin
                    begin_count = 1'b1;
                end else begin
                    begin_round = 1'b1;
                end
            end else begin
                idx_next     = idx_reg + CELL_AW'(1);
                changed_next = changed_now;
                if (col_reg == side_m1) begin
                    col_next = '0;
                    row_next = row_reg + SIDE_W'(1);
                end else begin
                    col_next = col_reg + SIDE_W'(1);
                end
            end
        end

        if (begin_round) begin
            idx_next     = '0;
            row_next     = '0;
            col_next     = '0;
            probe_next   = PR_SELF;
            changed_next = 1'b0;
            state_next   = S_PROBE;
        end

        if (begin_count) begin
            idx_next     = '0;
            cnt_next     = '0;
            cnt_vld_next = 1'b0;
            state_next   = S_COUNT;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_total  = out_reg;

    a_spread_other_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_EVAL) && ctl.wr_en
            |-> ctl.wr_bank != ctl.rd_bank)
        else $error("spread write hits the bank being read");

    a_idx_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_EVAL || state_reg == S_COUNT)
            |-> CELL_W'(idx_reg) < total)
        else $error("cell index beyond grid");

    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PROBE || state_reg == S_EVAL) |-> round_reg < rounds)
        else $error("spread round beyond requested count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COUNT || state_reg == S_CNT_LAST || state_reg == S_DONE)
            |-> cnt_reg <= total)
        else $error("infected count exceeds cell count");

endmodule
